// ----- hw/rtl/lbt_pkg.sv -----
// shared types and constants of the led blink timer table
package lbt_pkg;

  localparam int LED_COUNT = 64;
  localparam int IDX_W     = 6;
  localparam int LED_IN_W  = 8;
  localparam int RECIP_W   = 23;
  localparam int REM_W     = 11;

  localparam logic [31:0]        BLINK_PERIOD_MS = 32'd1000;
  // floor(2^32 / 1000): quotient estimate is exact or one low
  localparam logic [RECIP_W-1:0] PERIOD_RECIP    = 23'd4294967;
  localparam logic [REM_W-1:0]   PERIOD_REM      = 11'd1000;
  localparam logic [REM_W-1:0]   ON_REM          = 11'd500;

  typedef logic [LED_COUNT-1:0] act_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_STOP_ALL = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ELAPSED,
    ST_MUL,
    ST_REM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  led_number;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [31:0] blink_duration_ms;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [5:0] led_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] start_ms;
    logic [31:0] span_ms;
  } entry_t;

endpackage

// ----- hw/rtl/led_blink_timer_table_unit.sv -----
// led blink timer table: one timed blink entry per led, kept in an entry memory
//
// A command transfers at a rising edge with start high and busy low. Results
// come out one per cycle at most, each on res_o for exactly one cycle with
// res_valid_o high; the receiver cannot stall them. last_of_run marks the
// final result of a command.
// start and stop are done in the accept cycle: busy stays low, and the black
// result for a replaced or stopped entry appears in the next cycle.
// stop all and tick walk all LED_COUNT entries in ascending order and hold
// busy high meanwhile: an inactive entry, and an entry that stop all clears,
// takes only the scan step, and an active entry on tick takes five steps
// (memory read, elapsed time and expiry, reciprocal multiply, remainder,
// result). The tick steps are set by the entry memory's read latency and
// the modulo 1000 path.
// Active marks sit in flip-flops cleared by reset; the colour and timing
// memory is not cleared and its data is used only for entries marked active.
// Reset is asynchronous and active low and drops any walk in progress.
module led_blink_timer_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lbt_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          res_valid_o,
  output lbt_pkg::res_t res_o
);

  lbt_pkg::state_e state_q, state_d;
  lbt_pkg::idx_t   idx_q, idx_d;
  logic [1:0]      op_q, op_d;
  logic [31:0]     now_q, now_d;
  lbt_pkg::act_t   active_q, active_d;
  logic [31:0]     elapsed_q, elapsed_d;
  logic            expired_q, expired_d;
  logic [lbt_pkg::RECIP_W-1:0] quot_q, quot_d;
  logic [lbt_pkg::REM_W-1:0]   rem_q, rem_d;
  logic            res_valid_q, res_valid_d;
  lbt_pkg::res_t   res_q, res_d;

  lbt_pkg::entry_t mem [lbt_pkg::LED_COUNT];
  lbt_pkg::entry_t rdata_q;

  logic            accept;
  logic            idx_last;
  logic            led_in_range;
  lbt_pkg::idx_t   cmd_idx;
  lbt_pkg::idx_t   start_idx;
  lbt_pkg::act_t   cur_bit;
  logic            more_above;
  logic            mem_we;
  logic [54:0]     prod;
  logic [31:0]     quot_scaled;
  logic [31:0]     rem_full;
  logic [lbt_pkg::REM_W-1:0] rem_fix;
  logic            blink_on;

  assign busy        = (state_q != lbt_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign idx_last     = (idx_q == lbt_pkg::idx_t'(lbt_pkg::LED_COUNT - 1));
  assign led_in_range = (cmd_i.led_number < lbt_pkg::LED_IN_W'(lbt_pkg::LED_COUNT));
  assign cmd_idx      = cmd_i.led_number[lbt_pkg::IDX_W-1:0];
  assign start_idx    = led_in_range ? cmd_idx : lbt_pkg::idx_t'(lbt_pkg::LED_COUNT - 1);

  // any active entry beyond the current walk position
  assign cur_bit    = lbt_pkg::act_t'(1) << idx_q;
  assign more_above = |(active_q & ~(cur_bit | (cur_bit - lbt_pkg::act_t'(1))));

  assign prod        = 55'(elapsed_q) * 55'(lbt_pkg::PERIOD_RECIP);
  assign quot_scaled = 32'(quot_q) * lbt_pkg::BLINK_PERIOD_MS;
  assign rem_full    = elapsed_q - quot_scaled;
  assign rem_fix     = (rem_q >= lbt_pkg::PERIOD_REM) ? rem_q - lbt_pkg::PERIOD_REM : rem_q;
  assign blink_on    = !expired_q && (rem_fix < lbt_pkg::ON_REM);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbt_pkg::ST_IDLE: begin
        if (accept && (cmd_i.op == lbt_pkg::OP_STOP_ALL || cmd_i.op == lbt_pkg::OP_TICK)) begin
          state_d = lbt_pkg::ST_SCAN;
        end
      end
      lbt_pkg::ST_SCAN: begin
        if (active_q[idx_q] && op_q == lbt_pkg::OP_TICK) begin
          state_d = lbt_pkg::ST_ELAPSED;
        end else if (idx_last) begin
          state_d = lbt_pkg::ST_IDLE;
        end
      end
      lbt_pkg::ST_ELAPSED: state_d = lbt_pkg::ST_MUL;
      lbt_pkg::ST_MUL:     state_d = lbt_pkg::ST_REM;
      lbt_pkg::ST_REM:     state_d = lbt_pkg::ST_EMIT;
      lbt_pkg::ST_EMIT: begin
        state_d = idx_last ? lbt_pkg::ST_IDLE : lbt_pkg::ST_SCAN;
      end
      default: state_d = lbt_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    idx_d       = idx_q;
    op_d        = op_q;
    now_d       = now_q;
    active_d    = active_q;
    elapsed_d   = elapsed_q;
    expired_d   = expired_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    case (state_q)
      lbt_pkg::ST_IDLE: begin
        if (accept) begin
          op_d  = cmd_i.op;
          now_d = cmd_i.now_ms;
          idx_d = '0;
          case (cmd_i.op)
            lbt_pkg::OP_START: begin
              mem_we              = 1'b1;
              active_d[start_idx] = 1'b1;
              if (active_q[start_idx]) begin
                res_valid_d = 1'b1;
                res_d       = '{led_out: start_idx, red_out: '0, green_out: '0,
                                blue_out: '0, last_of_run: 1'b1};
              end
            end
            lbt_pkg::OP_STOP: begin
              if (led_in_range && active_q[cmd_idx]) begin
                active_d[cmd_idx] = 1'b0;
                res_valid_d       = 1'b1;
                res_d             = '{led_out: cmd_idx, red_out: '0, green_out: '0,
                                      blue_out: '0, last_of_run: 1'b1};
              end
            end
            default: begin
            end
          endcase
        end
      end
      lbt_pkg::ST_SCAN: begin
        if (active_q[idx_q] && op_q == lbt_pkg::OP_STOP_ALL) begin
          active_d[idx_q] = 1'b0;
          res_valid_d     = 1'b1;
          res_d           = '{led_out: idx_q, red_out: '0, green_out: '0,
                              blue_out: '0, last_of_run: !more_above};
        end
        if (!(active_q[idx_q] && op_q == lbt_pkg::OP_TICK)) begin
          idx_d = idx_q + lbt_pkg::idx_t'(1);
        end
      end
      lbt_pkg::ST_ELAPSED: begin
        elapsed_d = now_q - rdata_q.start_ms;
        expired_d = (elapsed_d >= rdata_q.span_ms);
      end
      lbt_pkg::ST_MUL: begin
        quot_d = prod[54:32];
      end
      lbt_pkg::ST_REM: begin
        rem_d = rem_full[lbt_pkg::REM_W-1:0];
      end
      lbt_pkg::ST_EMIT: begin
        res_valid_d = 1'b1;
        res_d.led_out     = idx_q;
        res_d.red_out     = blink_on ? rdata_q.red : '0;
        res_d.green_out   = blink_on ? rdata_q.green : '0;
        res_d.blue_out    = blink_on ? rdata_q.blue : '0;
        res_d.last_of_run = !more_above;
        if (expired_q) begin
          active_d[idx_q] = 1'b0;
        end
        idx_d = idx_q + lbt_pkg::idx_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbt_pkg::ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      active_q    <= active_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    expired_q <= expired_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    res_q     <= res_d;
  end

  // entry memory, one write port for start and one registered read for the walk
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[start_idx] <= '{red: cmd_i.red_in, green: cmd_i.green_in, blue: cmd_i.blue_in,
                          start_ms: cmd_i.now_ms, span_ms: cmd_i.blink_duration_ms};
    end
    if (state_q == lbt_pkg::ST_SCAN) begin
      rdata_q <= mem[idx_q];
    end
  end

endmodule

// ----- hw/rtl/lbt_checker.sv -----
// port-level checks for the led blink timer table, bound to the top level
module lbt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input lbt_pkg::cmd_t cmd_i,
  input logic          busy,
  input logic          res_valid_o,
  input lbt_pkg::res_t res_o
);

  // start and stop finish in their own cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.op == lbt_pkg::OP_START || cmd_i.op == lbt_pkg::OP_STOP)
    |=> !busy)
    else $error("busy after start or stop transfer");

  // stop all and tick always walk the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.op == lbt_pkg::OP_STOP_ALL || cmd_i.op == lbt_pkg::OP_TICK)
    |=> busy)
    else $error("walk did not start");

  // a result that is not last leaves the walk running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_of_run |-> busy)
    else $error("run ended without last mark");

  // a result seen while idle closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !busy |-> res_o.last_of_run)
    else $error("idle result not marked last");

endmodule

bind led_blink_timer_table_unit lbt_checker u_lbt_checker (.*);

// ----- dv/led_blink_timer_table_unit_test.sv -----
// self-checking testbench of the led blink timer table with a queue-fed driver and a monitor
`timescale 1ns / 1ps

module led_blink_timer_table_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [31:0] PERIOD_MS    = 32'd1000;
  localparam logic [31:0] ON_MS        = 32'd500;
  localparam logic [31:0] T0           = 32'hFFFF_FF00;

  typedef struct {
    lbt_pkg::cmd_t cmd;
    int unsigned   idle_pct;
  } queued_cmd_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  lbt_pkg::cmd_t cmd_i;
  logic          busy;
  logic          res_valid_o;
  lbt_pkg::res_t res_o;

  queued_cmd_t     pending_cmds[$];
  lbt_pkg::res_t   expected_colors[$];
  logic            blink_active[lbt_pkg::LED_COUNT] = '{default: 1'b0};
  lbt_pkg::entry_t blink_entries[lbt_pkg::LED_COUNT];
  int unsigned     fail_count;
  int unsigned     cycle_count;
  logic [127:0]    junk;

  led_blink_timer_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic lbt_pkg::res_t led_color(int unsigned led, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b);
    lbt_pkg::res_t c;
    c.led_out     = lbt_pkg::idx_t'(led);
    c.red_out     = r;
    c.green_out   = g;
    c.blue_out    = b;
    c.last_of_run = 1'b0;
    return c;
  endfunction

  // updates the table copy and queues the colors this command sets
  task automatic predict_colors(input lbt_pkg::cmd_t c);
    lbt_pkg::res_t run[$];
    int unsigned   led;
    logic [31:0]   elapsed;
    led = c.led_number;
    case (c.op)
      lbt_pkg::OP_START: begin
        if (led >= lbt_pkg::LED_COUNT) led = lbt_pkg::LED_COUNT - 1;
        if (blink_active[led]) run = {run, led_color(led, 8'd0, 8'd0, 8'd0)};
        blink_active[led]           = 1'b1;
        blink_entries[led].red      = c.red_in;
        blink_entries[led].green    = c.green_in;
        blink_entries[led].blue     = c.blue_in;
        blink_entries[led].start_ms = c.now_ms;
        blink_entries[led].span_ms  = c.blink_duration_ms;
      end
      lbt_pkg::OP_STOP: begin
        // no clamp here: an index past the table matches nothing
        if (led < lbt_pkg::LED_COUNT && blink_active[led]) begin
          run = {run, led_color(led, 8'd0, 8'd0, 8'd0)};
          blink_active[led] = 1'b0;
        end
      end
      lbt_pkg::OP_STOP_ALL: begin
        for (int i = 0; i < lbt_pkg::LED_COUNT; i++) begin
          if (blink_active[i]) begin
            run = {run, led_color(i, 8'd0, 8'd0, 8'd0)};
            blink_active[i] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < lbt_pkg::LED_COUNT; i++) begin
          if (blink_active[i]) begin
            elapsed = c.now_ms - blink_entries[i].start_ms;
            if (elapsed >= blink_entries[i].span_ms) begin
              run = {run, led_color(i, 8'd0, 8'd0, 8'd0)};
              blink_active[i] = 1'b0;
            end else if ((elapsed % PERIOD_MS) < ON_MS) begin
              run = {run, led_color(i, blink_entries[i].red, blink_entries[i].green,
                                    blink_entries[i].blue)};
            end else begin
              run = {run, led_color(i, 8'd0, 8'd0, 8'd0)};
            end
          end
        end
      end
    endcase
    if (run.size() != 0) run[run.size()-1].last_of_run = 1'b1;
    expected_colors = {expected_colors, run};
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic queue_cmd(input lbt_pkg::op_e op, input logic [7:0] led,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [31:0] dur, input logic [31:0] now,
                           input int unsigned pct);
    queued_cmd_t q;
    q.cmd.op                = op;
    q.cmd.led_number        = led;
    q.cmd.red_in            = r;
    q.cmd.green_in          = g;
    q.cmd.blue_in           = b;
    q.cmd.blink_duration_ms = dur;
    q.cmd.now_ms            = now;
    q.idle_pct              = pct;
    pending_cmds = {pending_cmds, q};
  endtask

  // driver: a command transfers when start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_colors(cmd_i);
        void'(pending_cmds.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
          start <= 1'b1;
          cmd_i <= pending_cmds[0].cmd;
        end else begin
          // garbage on the command bus while start is low
          junk  = {$urandom, $urandom, $urandom, $urandom};
          start <= 1'b0;
          cmd_i <= junk[$bits(lbt_pkg::cmd_t)-1:0];
        end
      end
    end
  end

  // monitor: results cannot be held off, each is checked at the edge ending its cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (expected_colors.size() == 0) begin
        note_failure($sformatf("unexpected result led %0d rgb %02h %02h %02h last %0b",
                               res_o.led_out, res_o.red_out, res_o.green_out,
                               res_o.blue_out, res_o.last_of_run));
      end else if (res_o !== expected_colors[0] || res_valid_o !== 1'b1) begin
        note_failure($sformatf({"mismatch: expected led %0d rgb %02h %02h %02h last %0b,",
                                " got led %0d rgb %02h %02h %02h last %0b"},
          expected_colors[0].led_out, expected_colors[0].red_out,
          expected_colors[0].green_out, expected_colors[0].blue_out,
          expected_colors[0].last_of_run, res_o.led_out, res_o.red_out,
          res_o.green_out, res_o.blue_out, res_o.last_of_run));
        void'(expected_colors.pop_front());
      end else begin
        void'(expected_colors.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0]  gen_now;
    logic [7:0]   led;
    logic [31:0]  dur;
    int unsigned  pick;
    int unsigned  pct;
    queued_cmd_t  q;

    rst_ni = 1'b0;

    // directed: empty table, clamp, replace, blink phase edges, expiry, stop cases
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_STOP_ALL, 8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_STOP,     8'd5,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_STOP,     8'd200, 8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_START,    8'd0,   8'hFF, 8'h00, 8'hFF, 32'd2000, T0,        20);
    queue_cmd(lbt_pkg::OP_START,    8'd255, 8'h01, 8'h02, 8'h03, '1,       T0,        20);
    queue_cmd(lbt_pkg::OP_START,    8'd63,  8'hAA, 8'h55, 8'hFF, '1,       T0,        20);
    queue_cmd(lbt_pkg::OP_START,    8'd10,  8'h80, 8'h80, 8'h80, 32'd0,    T0,        20);
    queue_cmd(lbt_pkg::OP_START,    8'd7,   8'h7F, 8'hFE, 8'h01, 32'd1000, T0,        20);
    queue_cmd(lbt_pkg::OP_STOP,     8'd71,  8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    T0 + 499,  20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    T0 + 500,  20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    T0 + 999,  20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    T0 + 1000, 20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    T0 + 2000, 20);
    queue_cmd(lbt_pkg::OP_START,    8'd3,   8'h11, 8'h22, 8'h33, 32'd100,  32'd5,     20);
    queue_cmd(lbt_pkg::OP_STOP,     8'd3,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_STOP,     8'd3,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_START,    8'd1,   8'h01, 8'h80, 8'hFE, 32'd5000, 32'd9,     20);
    queue_cmd(lbt_pkg::OP_START,    8'd2,   8'hFE, 8'h01, 8'h80, 32'd5000, 32'd9,     20);
    queue_cmd(lbt_pkg::OP_START,    8'd62,  8'h80, 8'hFE, 8'h01, 32'd5000, 32'd9,     20);
    queue_cmd(lbt_pkg::OP_STOP_ALL, 8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_STOP_ALL, 8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    32'd0,     20);
    queue_cmd(lbt_pkg::OP_TICK,     8'd0,   8'h00, 8'h00, 8'h00, 32'd0,    32'd12,    20);

    // random: a moving clock with mostly starts and ticks so entries blink and expire
    gen_now = $urandom;
    for (int i = 0; i < 76; i++) begin
      if (i < 19)      pct = 0;
      else if (i < 42) pct = 69;
      else if (i < 61) pct = 20;
      else             pct = 0;
      if ($urandom_range(19) == 0) gen_now = gen_now + $urandom;
      else                         gen_now = gen_now + $urandom_range(700);
      case ($urandom_range(3))
        0:       led = 8'($urandom_range(255, 64));
        1:       led = 8'($urandom_range(63));
        default: led = 8'($urandom_range(15));
      endcase
      case ($urandom_range(9))
        0:       dur = 32'd0;
        1:       dur = $urandom;
        2:       dur = 32'hFFFF_FFFF;
        default: dur = $urandom_range(6000, 1);
      endcase
      // fields an operation does not use carry random values
      q.cmd.red_in            = 8'($urandom);
      q.cmd.green_in          = 8'($urandom);
      q.cmd.blue_in           = 8'($urandom);
      q.cmd.blink_duration_ms = $urandom;
      q.cmd.led_number        = 8'($urandom);
      q.cmd.now_ms            = $urandom;
      q.idle_pct              = pct;
      pick = $urandom_range(99);
      if (pick < 38) begin
        q.cmd.op                = lbt_pkg::OP_START;
        q.cmd.led_number        = led;
        q.cmd.blink_duration_ms = dur;
        q.cmd.now_ms            = gen_now;
      end else if (pick < 50) begin
        q.cmd.op         = lbt_pkg::OP_STOP;
        q.cmd.led_number = led;
      end else if (pick < 54) begin
        q.cmd.op = lbt_pkg::OP_STOP_ALL;
      end else begin
        q.cmd.op     = lbt_pkg::OP_TICK;
        q.cmd.now_ms = gen_now;
      end
      pending_cmds = {pending_cmds, q};
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || expected_colors.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && expected_colors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
